// ===== hdl/bsc_pkg.sv =====
// Shared types, constants and helper functions of the barometric compensation block.
package bsc_pkg;

	localparam int DataW    = 64;
	localparam int CfgIdxW  = 3;
	localparam int InDepth  = 4;
	localparam int OutDepth = 2;

	localparam logic [CfgIdxW-1:0] RegTempCalib      = 3'd0;
	localparam logic [CfgIdxW-1:0] RegPressCalibLow  = 3'd1;
	localparam logic [CfgIdxW-1:0] RegPressCalibHigh = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPressCalibLast = 3'd3;

	localparam logic [DataW-1:0] TfineOffset = 64'd128000;
	localparam logic [DataW-1:0] PressFull   = 64'd1048576;
	localparam logic [DataW-1:0] PressScale  = 64'd3125;
	localparam logic [DataW-1:0] OneQ47      = 64'h0000_8000_0000_0000;
	localparam logic [31:0]      TempRound   = 32'd128;

	typedef struct packed {
		logic [19:0] adc_temp;
		logic [19:0] adc_press;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] temperature_centideg;
		logic [31:0]        pressure_q24_8;
		logic               zero_divisor;
	} out_item_t;

	typedef struct packed {
		logic [47:0] temp_calib;
		logic [63:0] press_low;
		logic [63:0] press_high;
		logic [15:0] press_last;
	} calib_t;

	function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
		logic signed [31:0] sv;
		sv = $signed(v);
		return 32'(sv >>> s);
	endfunction

	function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
		logic signed [63:0] sv;
		sv = $signed(v);
		return 64'(sv >>> s);
	endfunction

	function automatic logic [63:0] sext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

endpackage

// ===== hdl/bsc_queue.sv =====
// Small register queue used at the input and at the output of the block.
module bsc_queue import bsc_pkg::*; #(
	parameter type T     = in_item_t,
	parameter int  Depth = InDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  T     wdata,
	input  logic pop,
	output logic empty,
	output T     rdata
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	T                mem_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end
endmodule

// ===== hdl/bsc_mul.sv =====
// Shared 64-bit multiplier, low product half, built from three 32x32 partial products.
module bsc_mul import bsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] a,
	input  logic [DataW-1:0] b,
	output logic             done,
	output logic [DataW-1:0] prod
);
	localparam int HalfW = DataW / 2;

	logic [DataW-1:0] a_q;
	logic [DataW-1:0] b_q;
	logic [DataW-1:0] acc_q;
	logic [DataW-1:0] pp_s1;
	logic [1:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [HalfW-1:0] sel_a;
	logic [HalfW-1:0] sel_b;
	logic [DataW-1:0] pp_add;

	assign sel_a  = (cnt_q == 2'd2) ? a_q[DataW-1:HalfW] : a_q[HalfW-1:0];
	assign sel_b  = (cnt_q == 2'd1) ? b_q[DataW-1:HalfW] : b_q[HalfW-1:0];
	assign pp_add = (cnt_q >= 2'd2) ? (pp_s1 << HalfW) : pp_s1;
	assign done   = done_q;
	assign prod   = acc_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			pp_s1 <= DataW'(sel_a) * DataW'(sel_b);
			if (cnt_q != 2'd0) begin
				acc_q <= acc_q + pp_add;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hdl/bsc_div.sv =====
// Signed 64-bit restoring divider, one quotient bit per cycle, truncating toward zero.
module bsc_div import bsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DataW-1:0] num,
	input  logic [DataW-1:0] den,
	output logic             done,
	output logic [DataW-1:0] quo
);
	localparam int CntW = $clog2(DataW);

	logic [DataW-1:0] dm_q;
	logic [DataW-1:0] rem_q;
	logic [DataW-1:0] quo_q;
	logic             neg_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DataW:0]   trial;

	assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dm_q};
	assign done  = done_q;
	assign quo   = neg_q ? (DataW'(0) - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[DataW-1] ^ den[DataW-1];
			dm_q  <= den[DataW-1] ? (DataW'(0) - den) : den;
			quo_q <= num[DataW-1] ? (DataW'(0) - num) : num;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= trial[DataW] ? {rem_q[DataW-2:0], quo_q[DataW-1]} : trial[DataW-1:0];
			quo_q <= {quo_q[DataW-2:0], !trial[DataW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(DataW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== hdl/bsc_engine.sv =====
// Back end sequencer: walks the compensation formula through the shared multiplier and divider.
module bsc_engine import bsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  calib_t    calib,
	input  logic      in_empty,
	output logic      in_pop,
	input  in_item_t  sample,
	input  logic      out_full,
	output logic      out_push,
	output out_item_t result
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ISSUE = 6'b000010,
		S_MUL   = 6'b000100,
		S_DVST  = 6'b001000,
		S_DIV   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	localparam logic [3:0] StepV1t   = 4'd0;
	localparam logic [3:0] StepBsq   = 4'd1;
	localparam logic [3:0] StepV2t   = 4'd2;
	localparam logic [3:0] StepSq    = 4'd3;
	localparam logic [3:0] StepP6    = 4'd4;
	localparam logic [3:0] StepP5    = 4'd5;
	localparam logic [3:0] StepP3    = 4'd6;
	localparam logic [3:0] StepP2    = 4'd7;
	localparam logic [3:0] StepP1    = 4'd8;
	localparam logic [3:0] StepNum   = 4'd9;
	localparam logic [3:0] StepP9    = 4'd10;
	localparam logic [3:0] StepPsSq  = 4'd11;
	localparam logic [3:0] StepP8    = 4'd12;

	state_t           state_q;
	logic [3:0]       step_q;
	logic [19:0]      adc_t_q;
	logic [19:0]      adc_p_q;
	logic [31:0]      x_q;
	logic [31:0]      y_q;
	logic [31:0]      tfine_q;
	logic [63:0]      sq_q;
	logic [63:0]      acc1_q;
	logic [63:0]      acc2_q;
	logic [63:0]      den_q;
	logic [63:0]      num_q;
	logic [63:0]      p_q;
	logic [63:0]      t_q;
	logic             zf_q;

	logic [31:0]      t1;
	logic [63:0]      t2;
	logic [63:0]      t3;
	logic [63:0]      p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0]      a32;
	logic [31:0]      b32;
	logic [63:0]      v1w;
	logic [63:0]      ps;
	logic [63:0]      pdiff;
	logic [63:0]      op_a;
	logic [63:0]      op_b;
	logic             mul_start;
	logic             mul_done;
	logic [63:0]      mul_prod;
	logic             div_start;
	logic             div_done;
	logic [63:0]      div_quo;
	logic [63:0]      den_new;
	logic [31:0]      temp_sum;
	logic [63:0]      press_res;

	assign t1 = {16'b0, calib.temp_calib[15:0]};
	assign t2 = sext16(calib.temp_calib[31:16]);
	assign t3 = sext16(calib.temp_calib[47:32]);
	assign p1 = {48'b0, calib.press_low[15:0]};
	assign p2 = sext16(calib.press_low[31:16]);
	assign p3 = sext16(calib.press_low[47:32]);
	assign p4 = sext16(calib.press_low[63:48]);
	assign p5 = sext16(calib.press_high[15:0]);
	assign p6 = sext16(calib.press_high[31:16]);
	assign p7 = sext16(calib.press_high[47:32]);
	assign p8 = sext16(calib.press_high[63:48]);
	assign p9 = sext16(calib.press_last);

	assign a32   = {15'b0, adc_t_q[19:3]} - {15'b0, t1[15:0], 1'b0};
	assign b32   = {16'b0, adc_t_q[19:4]} - t1;
	assign v1w   = {{32{tfine_q[31]}}, tfine_q} - TfineOffset;
	assign ps    = asr64(p_q, 13);
	assign pdiff = PressFull - {44'b0, adc_p_q};

	always_comb begin
		case (step_q)
			StepV1t: begin
				op_a = {32'b0, a32};
				op_b = t2;
			end
			StepBsq: begin
				op_a = {32'b0, b32};
				op_b = {32'b0, b32};
			end
			StepV2t: begin
				op_a = {32'b0, y_q};
				op_b = t3;
			end
			StepSq: begin
				op_a = v1w;
				op_b = v1w;
			end
			StepP6: begin
				op_a = sq_q;
				op_b = p6;
			end
			StepP5: begin
				op_a = v1w;
				op_b = p5;
			end
			StepP3: begin
				op_a = sq_q;
				op_b = p3;
			end
			StepP2: begin
				op_a = v1w;
				op_b = p2;
			end
			StepP1: begin
				op_a = OneQ47 + acc1_q;
				op_b = p1;
			end
			StepNum: begin
				op_a = (pdiff << 31) - acc2_q;
				op_b = PressScale;
			end
			StepP9: begin
				op_a = p9;
				op_b = ps;
			end
			StepPsSq: begin
				op_a = t_q;
				op_b = ps;
			end
			StepP8: begin
				op_a = p8;
				op_b = p_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == S_ISSUE);
	assign div_start = (state_q == S_DVST);
	assign in_pop    = (state_q == S_IDLE) && !in_empty;
	assign out_push  = (state_q == S_OUT) && !out_full;
	assign den_new   = asr64(mul_prod, 33);

	assign temp_sum  = (tfine_q << 2) + tfine_q + TempRound;
	assign press_res = asr64(p_q + acc1_q + acc2_q, 8) + (p7 << 4);

	assign result.temperature_centideg = $signed(asr32(temp_sum, 8));
	assign result.pressure_q24_8       = zf_q ? 32'd0 : press_res[31:0];
	assign result.zero_divisor         = zf_q;

	bsc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	bsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (in_pop) begin
			adc_t_q <= sample.adc_temp;
			adc_p_q <= sample.adc_press;
		end
		if (state_q == S_DIV && div_done) begin
			p_q <= div_quo;
		end
		if (state_q == S_MUL && mul_done) begin
			case (step_q)
				StepV1t: begin
					x_q <= asr32(mul_prod[31:0], 11);
				end
				StepBsq: begin
					y_q <= asr32(mul_prod[31:0], 12);
				end
				StepV2t: begin
					tfine_q <= x_q + asr32(mul_prod[31:0], 14);
				end
				StepSq: begin
					sq_q <= mul_prod;
				end
				StepP6: begin
					acc2_q <= mul_prod;
				end
				StepP5: begin
					acc2_q <= acc2_q + (mul_prod << 17) + (p4 << 35);
				end
				StepP3: begin
					acc1_q <= asr64(mul_prod, 8);
				end
				StepP2: begin
					acc1_q <= acc1_q + (mul_prod << 12);
				end
				StepP1: begin
					den_q <= den_new;
				end
				StepNum: begin
					num_q <= mul_prod;
				end
				StepP9: begin
					t_q <= mul_prod;
				end
				StepPsSq: begin
					acc1_q <= asr64(mul_prod, 25);
				end
				StepP8: begin
					acc2_q <= asr64(mul_prod, 19);
				end
				default: begin
					t_q <= t_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			zf_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!in_empty) begin
						step_q  <= StepV1t;
						zf_q    <= 1'b0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (mul_done) begin
						if (step_q == StepP1 && den_new == '0) begin
							zf_q    <= 1'b1;
							state_q <= S_OUT;
						end else if (step_q == StepNum) begin
							state_q <= S_DVST;
						end else if (step_q == StepP8) begin
							state_q <= S_OUT;
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_DVST: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						step_q  <= StepP9;
						state_q <= S_ISSUE;
					end
				end
				S_OUT: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== hdl/baro_sensor_compensation.sv =====
// Top level of the barometric compensation block: calibration registers, queues and engine.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | push / full            | sample : in_item_t
//  result    | pop / empty            | result : out_item_t
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each item goes through a pop from the input queue, thirteen passes through the
// shared multiplier, a divider pass (start, 64 quotient bits, capture) and an
// output step.
// An item that hits a zero divisor stops after the ninth multiplier pass.
// Reset clears the calibration registers, both queues and the sequencer.
// The input queue keeps taking transactions while the engine works; a full
// result queue holds the engine at its output step.
module baro_sensor_compensation import bsc_pkg::*; #(
	parameter int InQueueDepth  = InDepth,
	parameter int OutQueueDepth = OutDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  in_item_t           sample,
	input  logic               pop,
	output logic               empty,
	output out_item_t          result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_data
);
	logic [47:0] temp_calib_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_last_q;
	calib_t      calib;
	logic        in_empty;
	logic        in_pop;
	in_item_t    in_head;
	logic        out_full;
	logic        out_push;
	out_item_t   out_item;

	assign cfg_ready = 1'b1;

	assign calib.temp_calib = temp_calib_q;
	assign calib.press_low  = press_low_q;
	assign calib.press_high = press_high_q;
	assign calib.press_last = press_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_low_q  <= '0;
			press_high_q <= '0;
			press_last_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				RegTempCalib: begin
					temp_calib_q <= cfg_data[47:0];
				end
				RegPressCalibLow: begin
					press_low_q <= cfg_data;
				end
				RegPressCalibHigh: begin
					press_high_q <= cfg_data;
				end
				RegPressCalibLast: begin
					press_last_q <= cfg_data[15:0];
				end
				default: begin
					press_last_q <= press_last_q;
				end
			endcase
		end
	end

	bsc_queue #(
		.T     (in_item_t),
		.Depth (InQueueDepth)
	) u_in_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (sample),
		.pop    (in_pop),
		.empty  (in_empty),
		.rdata  (in_head)
	);

	bsc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.calib    (calib),
		.in_empty (in_empty),
		.in_pop   (in_pop),
		.sample   (in_head),
		.out_full (out_full),
		.out_push (out_push),
		.result   (out_item)
	);

	bsc_queue #(
		.T     (out_item_t),
		.Depth (OutQueueDepth)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.full   (out_full),
		.wdata  (out_item),
		.pop    (pop),
		.empty  (empty),
		.rdata  (result)
	);
endmodule

// ===== verif/baro_sensor_compensation_test.sv =====
// Self-checking testbench of the barometric compensation block.
`timescale 1ns / 100ps

module baro_sensor_compensation_test;
	import bsc_pkg::*;

	typedef struct {
		logic [19:0] raw_t;
		logic [19:0] raw_p;
		bit          typed;
		out_item_t   want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	in_item_t           sample;
	logic               pop;
	logic               empty;
	out_item_t          result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [DataW-1:0]   cfg_data;

	logic [47:0] cal_t;
	logic [63:0] cal_pl;
	logic [63:0] cal_ph;
	logic [15:0] cal_p9;

	out_item_t  pending_readings[$];
	int         fail_count;
	bit         long_stall;

	baro_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.pop(pop), .empty(empty), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [63:0] sdiv_trunc(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] nm;
		logic [63:0] dm;
		logic [63:0] q;
		nm = num[63] ? -num : num;
		dm = den[63] ? -den : den;
		q = nm / dm;
		return (num[63] != den[63]) ? -q : q;
	endfunction

	function automatic out_item_t compensate(input logic [19:0] raw_t, input logic [19:0] raw_p);
		out_item_t r;
		logic signed [31:0] t1, t2, t3, a, b, v1t, v2t, tfine;
		logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
		logic signed [63:0] v1, v2, p, ps;
		t1 = {16'd0, cal_t[15:0]};
		t2 = {{16{cal_t[31]}}, cal_t[31:16]};
		t3 = {{16{cal_t[47]}}, cal_t[47:32]};
		a = {15'd0, raw_t[19:3]} - (t1 << 1);
		v1t = (a * t2) >>> 11;
		b = {16'd0, raw_t[19:4]} - t1;
		v2t = (((b * b) >>> 12) * t3) >>> 14;
		tfine = v1t + v2t;
		r.temperature_centideg = (tfine * 32'sd5 + 32'sd128) >>> 8;
		p1 = {48'd0, cal_pl[15:0]};
		p2 = {{48{cal_pl[31]}}, cal_pl[31:16]};
		p3 = {{48{cal_pl[47]}}, cal_pl[47:32]};
		p4 = {{48{cal_pl[63]}}, cal_pl[63:48]};
		p5 = {{48{cal_ph[15]}}, cal_ph[15:0]};
		p6 = {{48{cal_ph[31]}}, cal_ph[31:16]};
		p7 = {{48{cal_ph[47]}}, cal_ph[47:32]};
		p8 = {{48{cal_ph[63]}}, cal_ph[63:48]};
		p9 = {{48{cal_p9[15]}}, cal_p9};
		v1 = 64'(tfine) - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) << 12);
		v1 = (((64'sd1 << 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.pressure_q24_8 = '0;
			r.zero_divisor = 1'b1;
			return r;
		end
		p = 64'sd1048576 - {44'd0, raw_p};
		p = sdiv_trunc(((p << 31) - v2) * 64'sd3125, v1);
		ps = p >>> 13;
		v1 = (p9 * ps * ps) >>> 25;
		v2 = (p8 * p) >>> 19;
		p = ((p + v1 + v2) >>> 8) + (p7 << 4);
		r.pressure_q24_8 = p[31:0];
		r.zero_divisor = 1'b0;
		return r;
	endfunction

	task automatic write_calib(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			RegTempCalib:      cal_t = value[47:0];
			RegPressCalibLow:  cal_pl = value;
			RegPressCalibHigh: cal_ph = value;
			RegPressCalibLast: cal_p9 = value[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_calib(input logic [63:0] t, input logic [63:0] pl, input logic [63:0] ph,
			input logic [63:0] p9);
		write_calib(RegTempCalib, t);
		write_calib(RegPressCalibLow, pl);
		write_calib(RegPressCalibHigh, ph);
		write_calib(RegPressCalibLast, p9);
	endtask

	task automatic drain;
		int guard;
		guard = 0;
		while (pending_readings.size() != 0 && guard < 200_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic send_reading(input logic [19:0] raw_t, input logic [19:0] raw_p,
			input bit typed, input out_item_t want);
		out_item_t exp_r;
		exp_r = compensate(raw_t, raw_p);
		if (typed && exp_r != want) begin
			$error("table row disagrees: expected %h computed %h", want, exp_r);
			fail_count++;
		end
		push <= 1'b1;
		sample <= '{adc_temp: raw_t, adc_press: raw_p};
		@(posedge clk);
		while (full) @(posedge clk);
		pending_readings.push_back(exp_r);
		if ($urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_readings.size() == 0) begin
				$error("transaction with nothing expected: %h", result);
				fail_count++;
			end else begin
				out_item_t e;
				e = pending_readings.pop_front();
				if (result.temperature_centideg !== e.temperature_centideg) begin
					$error("temperature_centideg expected %0d actual %0d",
						e.temperature_centideg, result.temperature_centideg);
					fail_count++;
				end
				if (result.pressure_q24_8 !== e.pressure_q24_8) begin
					$error("pressure_q24_8 expected %h actual %h",
						e.pressure_q24_8, result.pressure_q24_8);
					fail_count++;
				end
				if (result.zero_divisor !== e.zero_divisor) begin
					$error("zero_divisor expected %b actual %b",
						e.zero_divisor, result.zero_divisor);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int mode;
		int run;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_stall) begin
				pop <= 1'b0;
				repeat (3000) @(posedge clk);
				long_stall = 1'b0;
			end
			mode = $urandom_range(0, 2);
			run = $urandom_range(1, 30);
			repeat (run) begin
				pop <= (mode == 0) ? 1'b1 : (mode == 1) ? ($urandom_range(0, 1) == 1) : 1'b0;
				@(posedge clk);
			end
		end
	end

	row_t directed[$];

	initial begin
		row_t r;
		out_item_t zd;
		logic [63:0] tc, pl, ph;
		fail_count = 0;
		long_stall = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal_t = '0;
		cal_pl = '0;
		cal_ph = '0;
		cal_p9 = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// calibration all zero after reset: P1 = 0 gives a zero divisor, temperature 0
		zd = '{temperature_centideg: 0, pressure_q24_8: 0, zero_divisor: 1'b1};
		directed = '{'{20'd0, 20'd0, 1'b1, zd}, '{20'hFFFFF, 20'hFFFFF, 1'b1, zd},
			'{20'hAAAAA, 20'h55555, 1'b1, zd}};
		foreach (directed[i])
			send_reading(directed[i].raw_t, directed[i].raw_p, directed[i].typed,
				directed[i].want);
		push <= 1'b0;
		drain();

		// typical calibration
		load_calib(64'({16'hFC18, 16'h6A4C, 16'h6B2A}),
			{16'h1E2B, 16'hEE6F, 16'h0BD0, 16'h8E6A},
			{16'hF4EA, 16'hF5FD, 16'h008C, 16'hFFF9}, 64'h0000_0000_0000_1770);
		directed = '{'{20'd0, 20'd0, 1'b0, zd}, '{20'hFFFFF, 20'hFFFFF, 1'b0, zd},
			'{20'h80000, 20'h65000, 1'b0, zd}, '{20'h7E000, 20'h50000, 1'b0, zd},
			'{20'hFFFFF, 20'd0, 1'b0, zd}, '{20'd0, 20'hFFFFF, 1'b0, zd},
			'{20'h55555, 20'hAAAAA, 1'b0, zd}, '{20'hAAAAA, 20'h55555, 1'b0, zd}};
		foreach (directed[i])
			send_reading(directed[i].raw_t, directed[i].raw_p, 1'b0, zd);
		push <= 1'b0;
		drain();

		// extremes: divisor overflow and wraps; unknown register index ignored
		load_calib(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_8000);
		write_calib(3'd4, 64'h1234);
		write_calib(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_reading(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 1'b0, zd);
		push <= 1'b0;
		drain();
		load_calib(64'({16'h8000, 16'h8000, 16'hFFFF}),
			{16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h7FFF);
		for (int i = 0; i < 4; i++)
			send_reading(i[0] ? 20'hFFFFF : 20'd0, i[1] ? 20'hFFFFF : 20'd0, 1'b0, zd);
		push <= 1'b0;
		drain();

		for (int ph_i = 0; ph_i < 6; ph_i++) begin
			if (ph_i % 2 == 0) begin
				tc = 64'({16'($urandom_range(16'hF000, 16'hFFFF)),
					16'($urandom_range(16'h6000, 16'h7000)),
					16'($urandom_range(16'h6000, 16'h7200))});
				pl = {16'($urandom_range(16'h1E00, 16'h2000)), 16'(-$urandom_range(100, 9000)),
					16'(-$urandom_range(4000, 12000)),
					16'($urandom_range(16'h8000, 16'hA000))};
				ph = {16'(-$urandom_range(1, 20000)), 16'($urandom_range(0, 500)),
					16'(-$urandom_range(1, 9000)), 16'($urandom_range(0, 65535))};
			end else begin
				tc = {$urandom, $urandom};
				pl = {$urandom, $urandom};
				ph = {$urandom, $urandom};
				if (ph_i == 3) pl[15:0] = '0;
			end
			load_calib(tc, pl, ph, 64'($urandom));
			if (ph_i == 2) long_stall = 1'b1;
			for (int k = 0; k < 70; k++) begin
				r.raw_t = (ph_i % 2 == 0 && k % 4 != 0) ?
					20'($urandom_range(20'h70000, 20'h90000)) : 20'($urandom);
				r.raw_p = (ph_i % 2 == 0 && k % 4 != 0) ?
					20'($urandom_range(20'h40000, 20'h70000)) : 20'($urandom);
				send_reading(r.raw_t, r.raw_p, 1'b0, zd);
				if ($urandom_range(0, 9) == 0) begin
					push <= 1'b0;
					repeat ($urandom_range(1, 400)) @(posedge clk);
				end
			end
			push <= 1'b0;
			drain();
		end

		if (fail_count == 0 && pending_readings.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
